### hdl/fplf_pkg.sv
// Package: shared widths, register indexes and fixed-point helpers for the ladder filter.
package fplf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RegIdxW = 2;

  localparam logic [RegIdxW-1:0] RegResonance = 2'd0;
  localparam logic [RegIdxW-1:0] RegCutoff    = 2'd1;
  localparam logic [RegIdxW-1:0] RegPoleFb    = 2'd2;

  localparam logic signed [DataW-1:0] ResonanceRst = 32'sd414188;
  localparam logic signed [DataW-1:0] CutoffRst    = 32'sd277873;
  localparam logic signed [DataW-1:0] PoleFbRst    = 32'sd81461;

  localparam logic signed [DataW-1:0] SatMax = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] SatMin = 32'sh80000000;

  // Saturate a 33-bit sum or difference to 32 bits.
  function automatic logic signed [DataW-1:0] sat33(input logic signed [DataW:0] v);
    logic signed [DataW-1:0] r;
    r = v[DataW-1:0];
    if (v[DataW] != v[DataW-1]) begin
      r = v[DataW] ? SatMin : SatMax;
    end
    return r;
  endfunction

endpackage

### hdl/four_pole_ladder_filter_unit.sv
// Top level: four-pole resonant ladder filter with a shared digit-serial multiplier.
//
// Usage:
//   Samples enter on sample_in_i with sample_in_valid_i / sample_in_ready_o and
//   leave on sample_out_o with sample_out_valid_o / sample_out_ready_i. One
//   result follows every sample. Coefficients are written through cfg_we_i,
//   cfg_idx_i and cfg_data_i; write them only while the block is idle, which the
//   block itself does not enforce. Unknown indexes are ignored. Each sample runs
//   sixteen fixed-point products on one multiplier that walks the multiplicand
//   four bits a cycle; each product loads its operands and then works through
//   eight digits. One sample is processed at a time. The result waits in an
//   output register, so the next sample is taken while it waits; a stalled
//   receiver holds that register, and the block holds its next result until the
//   register drains. Reset restores the coefficient defaults and clears all
//   filter state. The division by six of the cube uses a reciprocal multiply on
//   the same multiplier, with the high word of the raw product adjusted for
//   negatives.
module four_pole_ladder_filter_unit #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DIGIT_W   = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [fplf_pkg::RegIdxW-1:0]          cfg_idx_i,
  input  logic [fplf_pkg::DataW-1:0]            cfg_data_i,
  input  logic signed [fplf_pkg::DataW-1:0]     sample_in_i,
  input  logic                                  sample_in_valid_i,
  output logic                                  sample_in_ready_o,
  output logic signed [fplf_pkg::DataW-1:0]     sample_out_o,
  output logic                                  sample_out_valid_o,
  input  logic                                  sample_out_ready_i
);

  localparam int unsigned W      = fplf_pkg::DataW;
  localparam int unsigned PW     = 2 * W;
  localparam int unsigned NDig   = W / DIGIT_W;
  localparam int unsigned CntW   = $clog2(NDig + 1);

  // sequencer step codes
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDrvM  = 4'd1;
  localparam logic [3:0] StDrvS  = 4'd2;
  localparam logic [3:0] StPoleA = 4'd3;
  localparam logic [3:0] StPoleB = 4'd4;
  localparam logic [3:0] StPoleC = 4'd5;
  localparam logic [3:0] StPoleS = 4'd6;
  localparam logic [3:0] StSq    = 4'd7;
  localparam logic [3:0] StCube  = 4'd8;
  localparam logic [3:0] StDiv   = 4'd9;
  localparam logic [3:0] StFix   = 4'd10;
  localparam logic [3:0] StOut   = 4'd11;

  logic signed [W-1:0] res_q, cut_q, pfb_q;
  logic signed [W-1:0] st_q [4];
  logic signed [W-1:0] pv_q [4];   // prev_drive, prev_stage_one..three
  logic signed [W-1:0] x_q, drive_q, sum_q, cube_q, quo_q;
  logic [1:0]          pole_q;
  logic [3:0]          state_q, state_d;
  logic signed [W-1:0] out_q;
  logic                out_vld_q;
  logic                out_free;

  // multiplier: multiplicand shifts out DIGIT_W bits a cycle, LSB first
  logic [W-1:0]         mcand_q;
  logic signed [W-1:0]  mplier_q;
  logic signed [PW-1:0] acc_q;
  logic [CntW-1:0]      cnt_q;
  logic                 mbusy_q, mdone_q;
  logic                 mstart;
  logic signed [W-1:0]  ma, mb;

  logic signed [W+DIGIT_W:0] pp;
  logic [DIGIT_W-1:0]        dig;
  logic                      last_dig;

  assign dig      = mcand_q[DIGIT_W-1:0];
  assign last_dig = (cnt_q == CntW'(NDig - 1));
  // top digit carries the sign weight
  assign pp = last_dig
    ? (W+DIGIT_W+1)'($signed(dig)) * (W+DIGIT_W+1)'(mplier_q)
    : (W+DIGIT_W+1)'($signed({1'b0, dig})) * (W+DIGIT_W+1)'(mplier_q);

  // rounding and saturation of the full product
  logic signed [PW:0]  rnd;
  logic signed [PW:0]  shr;
  logic signed [W-1:0] rsat;
  always_comb begin
    rnd  = {acc_q[PW-1], acc_q} + (PW+1)'(64'sd1 <<< (FRAC_BITS - 1));
    shr  = rnd >>> FRAC_BITS;
    rsat = shr[W-1:0];
    if (shr > (PW+1)'(fplf_pkg::SatMax)) rsat = fplf_pkg::SatMax;
    else if (shr < (PW+1)'(fplf_pkg::SatMin)) rsat = fplf_pkg::SatMin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mdone_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      mdone_q <= 1'b0;
      if (mstart) begin
        mbusy_q <= 1'b1;
        cnt_q   <= '0;
      end else if (mbusy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (last_dig) begin
          mbusy_q <= 1'b0;
          mdone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mstart) begin
      mcand_q  <= ma;
      mplier_q <= mb;
      acc_q    <= '0;
    end else if (mbusy_q) begin
      mcand_q <= mcand_q >> DIGIT_W;
      acc_q   <= acc_q + (PW'(pp) <<< (DIGIT_W * cnt_q));
    end
  end

  // reciprocal for /6: q = (c * 0x2AAAAAAB) >> 32, plus one when c is negative
  localparam logic signed [W-1:0] Recip6 = 32'sh2AAAAAAB;

  logic signed [W-1:0] stage_in, stage_prev;

  always_comb begin
    stage_in   = (pole_q == 2'd0) ? drive_q : st_q[pole_q - 2'd1];
    stage_prev = pv_q[pole_q];
  end

  // operand select for each step
  always_comb begin
    ma = x_q; mb = x_q;
    unique case (state_q)
      StDrvM:  begin ma = res_q;    mb = st_q[3]; end
      StPoleA: begin ma = stage_in; mb = cut_q;   end
      StPoleB: begin ma = stage_prev; mb = cut_q; end
      StPoleC: begin ma = pfb_q;    mb = st_q[pole_q]; end
      StSq:    begin ma = st_q[3];  mb = st_q[3]; end
      StCube:  begin ma = rsat;     mb = st_q[3]; end
      StDiv:   begin ma = rsat;     mb = Recip6;  end
      default: begin ma = x_q;      mb = x_q; end
    endcase
  end

  // divide-by-six uses the raw product high word, not the rounded one
  logic                step_go;
  logic signed [W-1:0] q_est;
  assign q_est = acc_q[PW-1:W] + W'(cube_q[W-1]);

  assign sample_in_ready_o = (state_q == StIdle);
  assign out_free          = !out_vld_q || sample_out_ready_i;
  assign step_go           = mdone_q;

  always_comb begin
    state_d = state_q;
    mstart  = 1'b0;
    unique case (state_q)
      StIdle:  if (sample_in_valid_i && sample_in_ready_o) state_d = StDrvM;
      StDrvM:  begin mstart = 1'b1; state_d = StDrvS; end
      StDrvS:  if (step_go) state_d = StPoleA;
      StPoleA: begin mstart = 1'b1; state_d = StPoleB; end
      StPoleB: if (step_go) begin mstart = 1'b1; state_d = StPoleC; end
      StPoleC: if (step_go) begin mstart = 1'b1; state_d = StPoleS; end
      StPoleS: if (step_go) state_d = (pole_q == 2'd3) ? StSq : StPoleA;
      StSq:    begin mstart = 1'b1; state_d = StCube; end
      StCube:  if (step_go) begin mstart = 1'b1; state_d = StDiv; end
      StDiv:   if (step_go) begin mstart = 1'b1; state_d = StFix; end
      StFix:   if (step_go) state_d = StOut;
      StOut:   if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      res_q      <= fplf_pkg::ResonanceRst;
      cut_q      <= fplf_pkg::CutoffRst;
      pfb_q      <= fplf_pkg::PoleFbRst;
      st_q       <= '{default: '0};
      pv_q       <= '{default: '0};
      pole_q     <= 2'd0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fplf_pkg::RegResonance: res_q <= cfg_data_i;
          fplf_pkg::RegCutoff:    cut_q <= cfg_data_i;
          fplf_pkg::RegPoleFb:    pfb_q <= cfg_data_i;
          default: ;
        endcase
      end
      // load a new result, or drop the old one once it has been transferred
      if (state_q == StOut && out_free) out_vld_q <= 1'b1;
      else if (sample_out_ready_i) out_vld_q <= 1'b0;
      if (state_q == StPoleS && step_go) begin
        st_q[pole_q] <= fplf_pkg::sat33((W+1)'(sum_q) - (W+1)'(rsat));
        pv_q[pole_q] <= stage_in;
        pole_q       <= pole_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && sample_in_valid_i && sample_in_ready_o) x_q <= sample_in_i;
    if (state_q == StDrvS && step_go)
      drive_q <= fplf_pkg::sat33((W+1)'(x_q) - (W+1)'(rsat));
    if (state_q == StPoleB && step_go) sum_q <= rsat;
    if (state_q == StPoleC && step_go)
      sum_q <= fplf_pkg::sat33((W+1)'(sum_q) + (W+1)'(rsat));
    if (state_q == StDiv && step_go) cube_q <= rsat;
    // truncate towards zero: floor of the high word, plus one for a negative cube
    if (state_q == StFix && step_go) quo_q <= q_est;
    if (state_q == StOut && out_free)
      out_q <= fplf_pkg::sat33((W+1)'(st_q[3]) - (W+1)'(quo_q));
  end

  assign sample_out_o       = out_q;
  assign sample_out_valid_o = out_vld_q;

endmodule
